FILE: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

    localparam int MAX_LEVELS_DEF  = 8;
    localparam int MAX_ROOTS_DEF   = 16;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int RST_LEVEL_COUNT = 8;
    localparam int RST_ROOT_COUNT  = 16;
    localparam int RST_MIN_SHIFT   = 6;

    localparam logic [1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [1:0] REG_ROOT_COUNT  = 2'd1;
    localparam logic [1:0] REG_MIN_SHIFT   = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_ALLOC_AT,
        K_FREE,
        K_REINIT
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BADSIZE,
        ST_TOOBIG,
        ST_MISALIGNED,
        ST_UNAVAILABLE,
        ST_ALREADYFREE
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN_PREP,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_PREP,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        PH_SPLIT,
        PH_AT_PROBE,
        PH_AT_SPLIT,
        PH_FR_PROBE,
        PH_FR_BUDDY,
        PH_FR_SET
    } t_phase;

endpackage

FILE: rtl/core/bba_store.sv
`timescale 1ns / 1ps

module bba_store #(
    parameter int WORDS = 65,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data
);

    logic [63:0] mem [WORDS];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/buddy_block_allocator_core.sv
`timescale 1ns / 1ps

// Buddy allocator whose free bitmaps for all size levels live in one 64-bit-wide
// synchronous memory, one bit per block. Each item takes one result beat. Each
// step reads a store word through the read port and may write it back through
// the write port: allocate scans the words of each level from the requested one
// upward and then splits the found block down level by level; allocate-at and
// free probe or merge level by level between a decode step and the result.
// Reinitialize, and reset, run a clearing pass that writes every one of the
// (MAX_ROOTS << MAX_LEVELS) / 64 + 1 store words once, 65 with the defaults,
// during which no item is taken. Configuration writes are taken at any time.
module buddy_block_allocator_core #(
    parameter int MAX_LEVELS = bba_pkg::MAX_LEVELS_DEF,
    parameter int MAX_ROOTS  = bba_pkg::MAX_ROOTS_DEF,
    parameter int ADDR_BITS  = bba_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_result_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STORE_WORDS = ((MAX_ROOTS << MAX_LEVELS) / 64) + 1;
    localparam int WA_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int POS_W = WA_W + 6;
    localparam int LV_W  = $clog2(MAX_LEVELS + 1);
    localparam int RT_W  = $clog2(MAX_ROOTS + 1);
    localparam int RST_LC_EFF = (bba_pkg::RST_LEVEL_COUNT > MAX_LEVELS) ?
                                MAX_LEVELS : bba_pkg::RST_LEVEL_COUNT;
    localparam int RST_RT_EFF = (bba_pkg::RST_ROOT_COUNT > MAX_ROOTS) ?
                                MAX_ROOTS : bba_pkg::RST_ROOT_COUNT;
    localparam logic [31:0] RES_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [WA_W-1:0] LAST_W = WA_W'(STORE_WORDS - 1);

    function automatic logic [POS_W-1:0] f_base(input logic [LV_W-1:0] l);
        logic [POS_W-1:0] tot;
        tot = POS_W'(MAX_ROOTS) << MAX_LEVELS;
        return tot - (POS_W'(MAX_ROOTS) << (MAX_LEVELS - int'(l)));
    endfunction

    function automatic logic [POS_W-1:0] f_count(input logic [LV_W-1:0] l,
                                                 input logic [LV_W-1:0] lc,
                                                 input logic [RT_W-1:0] rt);
        logic [POS_W-1:0] c;
        c = '0;
        if (l < lc) begin
            c = POS_W'(rt) << (lc - l - LV_W'(1));
        end
        return c;
    endfunction

    // bits of a word whose position falls in [lo, hi)
    function automatic logic [63:0] f_mask(input logic [WA_W-1:0]  w,
                                           input logic [POS_W-1:0] lo,
                                           input logic [POS_W-1:0] hi);
        logic [63:0]      m;
        logic [POS_W-1:0] p;
        m = '0;
        for (int b = 0; b < 64; b++) begin
            p = {w, 6'(b)};
            m[b] = (p >= lo) && (p < hi);
        end
        return m;
    endfunction

    bba_pkg::t_state  r_state, n_state;
    bba_pkg::t_phase  r_phase, n_phase;
    bba_pkg::t_kind   r_kind, n_kind;
    bba_pkg::t_status r_wst, n_wst, r_ost, n_ost;

    logic [3:0]        r_lc;
    logic [4:0]        r_rt, r_ms;
    logic [31:0]       r_size, n_size, r_addr, n_addr;
    logic [4:0]        r_s, n_s;
    logic [LV_W-1:0]   r_lv, n_lv, r_l, n_l;
    logic [POS_W-1:0]  r_i, n_i, r_cur, n_cur;
    logic [WA_W-1:0]   r_word, n_word, r_w, n_w;
    logic [5:0]        r_bit, n_bit;
    logic              r_inr, n_inr;
    logic [POS_W-1:0]  r_lo, n_lo, r_hi, n_hi;
    logic              r_clr_item, n_clr_item;
    logic [31:0]       r_wres, n_wres, r_ores, n_ores;
    logic              r_ovalid, n_ovalid;

    logic              rd_en, wr_en;
    logic [WA_W-1:0]   rd_addr, wr_addr;
    logic [63:0]       rd_data, wr_data;

    logic [LV_W-1:0]   eff_lc;
    logic [RT_W-1:0]   eff_rt;
    logic [POS_W-1:0]  cur_base, cur_cnt, cur_pos, top_base;
    logic              up_ok, lv0_up_ok, up2_ok;

    logic [4:0]        dec_s;
    logic              pow2, below, toobig, misal, oob;
    logic [5:0]        diff;
    logic [LV_W-1:0]   dec_lv;
    logic [31:0]       idx32;
    logic [POS_W-1:0]  cnt_lv;

    logic [63:0]       scan_masked;
    logic              scan_hit;
    logic [5:0]        scan_b;
    logic [POS_W-1:0]  scan_idx, hm1;
    logic [WA_W-1:0]   scan_last;

    logic              bit_get;
    logic [63:0]       set_word, clr_word;
    logic [LV_W-1:0]   dshift;
    logic [POS_W-1:0]  down_idx;

    bba_store #(
        .WORDS (STORE_WORDS),
        .AW    (WA_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // configuration
    always_comb begin
        if (r_lc == 4'd0) begin
            eff_lc = LV_W'(1);
        end else if (int'(r_lc) > MAX_LEVELS) begin
            eff_lc = LV_W'(MAX_LEVELS);
        end else begin
            eff_lc = LV_W'(r_lc);
        end
        if (r_rt == 5'd0) begin
            eff_rt = RT_W'(1);
        end else if (int'(r_rt) > MAX_ROOTS) begin
            eff_rt = RT_W'(MAX_ROOTS);
        end else begin
            eff_rt = RT_W'(r_rt);
        end
    end

    always_comb begin
        case (paddr[3:2])
            bba_pkg::REG_LEVEL_COUNT: prdata = 32'(r_lc);
            bba_pkg::REG_ROOT_COUNT:  prdata = 32'(r_rt);
            bba_pkg::REG_MIN_SHIFT:   prdata = 32'(r_ms);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // geometry of the level being worked on
    assign cur_base  = f_base(r_l);
    assign cur_cnt   = f_count(r_l, eff_lc, eff_rt);
    assign cur_pos   = cur_base + r_i;
    assign top_base  = f_base(eff_lc - LV_W'(1));
    assign up_ok     = ({1'b0, r_l} + (LV_W+1)'(1)) < {1'b0, eff_lc};
    assign lv0_up_ok = ({1'b0, r_lv} + (LV_W+1)'(1)) < {1'b0, eff_lc};
    assign up2_ok    = ({1'b0, r_l} + (LV_W+1)'(2)) < {1'b0, eff_lc};

    // size and address decode
    always_comb begin
        dec_s = '0;
        for (int b = 0; b < 32; b++) begin
            if (r_size[b]) begin
                dec_s = dec_s | 5'(b);
            end
        end
    end

    assign pow2   = (r_size != 32'd0) && ((r_size & (r_size - 32'd1)) == 32'd0);
    assign below  = dec_s < r_ms;
    assign diff   = {1'b0, dec_s} - {1'b0, r_ms};
    assign toobig = diff >= 6'(eff_lc);
    assign dec_lv = LV_W'(diff);
    assign idx32  = r_addr >> dec_s;
    assign misal  = (r_addr & (r_size - 32'd1)) != 32'd0;
    assign cnt_lv = f_count(dec_lv, eff_lc, eff_rt);
    assign oob    = idx32 >= 32'(cnt_lv);

    // lowest free block in the scanned word
    assign scan_masked = rd_data & f_mask(r_w, r_lo, r_hi);
    assign scan_hit    = |scan_masked;
    always_comb begin
        scan_b = '0;
        for (int b = 63; b >= 0; b--) begin
            if (scan_masked[b]) begin
                scan_b = 6'(b);
            end
        end
    end
    assign scan_idx  = {r_w, scan_b} - r_lo;
    assign hm1       = r_hi - POS_W'(1);
    assign scan_last = hm1[POS_W-1:6];

    assign bit_get  = r_inr & rd_data[r_bit];
    assign set_word = rd_data | (64'd1 << r_bit);
    assign clr_word = rd_data & ~(64'd1 << r_bit);
    assign dshift   = r_l - r_lv - LV_W'(1);
    assign down_idx = (r_cur >> dshift) ^ POS_W'(1);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_size     = r_size;
        n_addr     = r_addr;
        n_s        = r_s;
        n_lv       = r_lv;
        n_l        = r_l;
        n_i        = r_i;
        n_cur      = r_cur;
        n_word     = r_word;
        n_bit      = r_bit;
        n_inr      = r_inr;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_w        = r_w;
        n_clr_item = r_clr_item;
        n_wst      = r_wst;
        n_wres     = r_wres;
        n_ost      = r_ost;
        n_ores     = r_ores;
        n_ovalid   = r_ovalid;
        rd_en      = 1'b0;
        rd_addr    = r_word;
        wr_en      = 1'b0;
        wr_addr    = r_word;
        wr_data    = rd_data;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            bba_pkg::S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_w;
                wr_data = f_mask(r_w, r_lo, r_hi);
                if (r_w == LAST_W) begin
                    if (r_clr_item) begin
                        n_wst   = bba_pkg::ST_OK;
                        n_wres  = '0;
                        n_state = bba_pkg::S_DONE;
                    end else begin
                        n_state = bba_pkg::S_IDLE;
                    end
                end else begin
                    n_w = r_w + WA_W'(1);
                end
            end
            bba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = bba_pkg::t_kind'(i_kind);
                    n_size  = i_size_bytes;
                    n_addr  = i_address;
                    n_wres  = '0;
                    n_state = bba_pkg::S_CHECK;
                end
            end
            bba_pkg::S_CHECK: begin
                n_s  = dec_s;
                n_lv = dec_lv;
                n_l  = dec_lv;
                if (r_kind == bba_pkg::K_REINIT) begin
                    n_lo       = top_base;
                    n_hi       = top_base + POS_W'(eff_rt);
                    n_w        = '0;
                    n_clr_item = 1'b1;
                    n_state    = bba_pkg::S_CLEAR;
                end else if (!pow2 || below) begin
                    n_wst   = bba_pkg::ST_BADSIZE;
                    n_state = bba_pkg::S_DONE;
                end else if (toobig) begin
                    n_wst   = bba_pkg::ST_TOOBIG;
                    n_state = bba_pkg::S_DONE;
                end else if (r_kind == bba_pkg::K_ALLOC) begin
                    n_state = bba_pkg::S_SCAN_PREP;
                end else if (misal) begin
                    n_wst   = bba_pkg::ST_MISALIGNED;
                    n_state = bba_pkg::S_DONE;
                end else if (oob) begin
                    n_wst   = bba_pkg::ST_UNAVAILABLE;
                    n_state = bba_pkg::S_DONE;
                end else begin
                    n_i     = POS_W'(idx32);
                    n_cur   = POS_W'(idx32);
                    n_phase = (r_kind == bba_pkg::K_ALLOC_AT) ? bba_pkg::PH_AT_PROBE :
                                                                bba_pkg::PH_FR_PROBE;
                    n_state = bba_pkg::S_PREP;
                end
            end
            bba_pkg::S_SCAN_PREP: begin
                n_lo    = cur_base;
                n_hi    = cur_base + cur_cnt;
                n_w     = cur_base[POS_W-1:6];
                n_state = bba_pkg::S_SCAN_RD;
            end
            bba_pkg::S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_w;
                n_state = bba_pkg::S_SCAN_EVAL;
            end
            bba_pkg::S_SCAN_EVAL: begin
                if (scan_hit) begin
                    // claim the block in the same word, then split downward
                    wr_en   = 1'b1;
                    wr_addr = r_w;
                    wr_data = rd_data & ~(64'd1 << scan_b);
                    if (r_l > r_lv) begin
                        n_l     = r_l - LV_W'(1);
                        n_cur   = scan_idx << 1;
                        n_i     = (scan_idx << 1) | POS_W'(1);
                        n_phase = bba_pkg::PH_SPLIT;
                        n_state = bba_pkg::S_PREP;
                    end else begin
                        n_wst   = bba_pkg::ST_OK;
                        n_wres  = (32'(scan_idx) << r_s) & RES_MASK;
                        n_state = bba_pkg::S_DONE;
                    end
                end else if (r_w == scan_last) begin
                    if (up_ok) begin
                        n_l     = r_l + LV_W'(1);
                        n_state = bba_pkg::S_SCAN_PREP;
                    end else begin
                        n_wst   = bba_pkg::ST_UNAVAILABLE;
                        n_state = bba_pkg::S_DONE;
                    end
                end else begin
                    n_w     = r_w + WA_W'(1);
                    n_state = bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_PREP: begin
                n_word  = cur_pos[POS_W-1:6];
                n_bit   = cur_pos[5:0];
                n_inr   = r_i < cur_cnt;
                n_state = bba_pkg::S_READ;
            end
            bba_pkg::S_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_word;
                n_state = bba_pkg::S_EVAL;
            end
            bba_pkg::S_EVAL: begin
                case (r_phase)
                    bba_pkg::PH_SPLIT: begin
                        wr_en   = r_inr;
                        wr_data = set_word;
                        if (r_l > r_lv) begin
                            n_l     = r_l - LV_W'(1);
                            n_cur   = r_cur << 1;
                            n_i     = (r_cur << 1) | POS_W'(1);
                            n_state = bba_pkg::S_PREP;
                        end else begin
                            n_wst   = bba_pkg::ST_OK;
                            n_wres  = (32'(r_cur) << r_s) & RES_MASK;
                            n_state = bba_pkg::S_DONE;
                        end
                    end
                    bba_pkg::PH_AT_PROBE: begin
                        if (bit_get) begin
                            wr_en   = 1'b1;
                            wr_data = clr_word;
                            if (r_l > r_lv) begin
                                n_l     = r_l - LV_W'(1);
                                n_i     = down_idx;
                                n_phase = bba_pkg::PH_AT_SPLIT;
                                n_state = bba_pkg::S_PREP;
                            end else begin
                                n_wst   = bba_pkg::ST_OK;
                                n_wres  = r_addr & RES_MASK;
                                n_state = bba_pkg::S_DONE;
                            end
                        end else if (up_ok) begin
                            n_l     = r_l + LV_W'(1);
                            n_i     = r_i >> 1;
                            n_state = bba_pkg::S_PREP;
                        end else begin
                            n_wst   = bba_pkg::ST_UNAVAILABLE;
                            n_state = bba_pkg::S_DONE;
                        end
                    end
                    bba_pkg::PH_AT_SPLIT: begin
                        // free the buddy half on the way down
                        wr_en   = r_inr;
                        wr_data = set_word;
                        if (r_l > r_lv) begin
                            n_l     = r_l - LV_W'(1);
                            n_i     = down_idx;
                            n_state = bba_pkg::S_PREP;
                        end else begin
                            n_wst   = bba_pkg::ST_OK;
                            n_wres  = r_addr & RES_MASK;
                            n_state = bba_pkg::S_DONE;
                        end
                    end
                    bba_pkg::PH_FR_PROBE: begin
                        if (bit_get) begin
                            n_wst   = bba_pkg::ST_ALREADYFREE;
                            n_state = bba_pkg::S_DONE;
                        end else if (up_ok) begin
                            n_l     = r_l + LV_W'(1);
                            n_i     = r_i >> 1;
                            n_state = bba_pkg::S_PREP;
                        end else begin
                            n_l     = r_lv;
                            n_state = bba_pkg::S_PREP;
                            if (lv0_up_ok) begin
                                n_i     = r_cur ^ POS_W'(1);
                                n_phase = bba_pkg::PH_FR_BUDDY;
                            end else begin
                                n_i     = r_cur;
                                n_phase = bba_pkg::PH_FR_SET;
                            end
                        end
                    end
                    bba_pkg::PH_FR_BUDDY: begin
                        n_state = bba_pkg::S_PREP;
                        if (bit_get) begin
                            // buddy free: take it and merge one level up
                            wr_en   = 1'b1;
                            wr_data = clr_word;
                            n_cur   = r_cur >> 1;
                            n_l     = r_l + LV_W'(1);
                            if (up2_ok) begin
                                n_i = (r_cur >> 1) ^ POS_W'(1);
                            end else begin
                                n_i     = r_cur >> 1;
                                n_phase = bba_pkg::PH_FR_SET;
                            end
                        end else begin
                            n_i     = r_cur;
                            n_phase = bba_pkg::PH_FR_SET;
                        end
                    end
                    bba_pkg::PH_FR_SET: begin
                        wr_en   = r_inr;
                        wr_data = set_word;
                        n_wst   = bba_pkg::ST_OK;
                        n_state = bba_pkg::S_DONE;
                    end
                    default: begin
                        n_state = bba_pkg::S_IDLE;
                    end
                endcase
            end
            bba_pkg::S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ost    = r_wst;
                    n_ores   = r_wres;
                    n_ovalid = 1'b1;
                    n_state  = bba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bba_pkg::S_CLEAR;
            r_ovalid   <= 1'b0;
            r_lc       <= 4'(bba_pkg::RST_LEVEL_COUNT);
            r_rt       <= 5'(bba_pkg::RST_ROOT_COUNT);
            r_ms       <= 5'(bba_pkg::RST_MIN_SHIFT);
            r_w        <= '0;
            r_lo       <= f_base(LV_W'(RST_LC_EFF - 1));
            r_hi       <= f_base(LV_W'(RST_LC_EFF - 1)) + POS_W'(RST_RT_EFF);
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ovalid   <= n_ovalid;
            r_w        <= n_w;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_clr_item <= n_clr_item;
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    bba_pkg::REG_LEVEL_COUNT: r_lc <= pwdata[3:0];
                    bba_pkg::REG_ROOT_COUNT:  r_rt <= pwdata[4:0];
                    bba_pkg::REG_MIN_SHIFT:   r_ms <= pwdata[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_kind  <= n_kind;
        r_size  <= n_size;
        r_addr  <= n_addr;
        r_s     <= n_s;
        r_lv    <= n_lv;
        r_l     <= n_l;
        r_i     <= n_i;
        r_cur   <= n_cur;
        r_word  <= n_word;
        r_bit   <= n_bit;
        r_inr   <= n_inr;
        r_wst   <= n_wst;
        r_wres  <= n_wres;
        r_ost   <= n_ost;
        r_ores  <= n_ores;
    end

    assign o_in_stall       = (r_state != bba_pkg::S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ost;
    assign o_result_address = r_ores;

endmodule

FILE: rtl/core/bba_checker.sv
`timescale 1ns / 1ps

module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [31:0] o_result_address,
    input logic        psel,
    input logic        penable,
    input logic        pready
);

    // a result beat held back must stay offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // one item in flight: input closes right after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while an item is in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != 3'(bba_pkg::ST_OK)) |-> o_result_address == 32'd0)
        else $error("failed request reports an address");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'(bba_pkg::ST_ALREADYFREE))
        else $error("status code out of range");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("config access not completed");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

FILE: sim/buddy_block_allocator_core_tb.sv
`timescale 1ns / 1ps

module buddy_block_allocator_core_tb;
    import bba_pkg::*;

    localparam int NLV = MAX_LEVELS_DEF;
    localparam int NRT = MAX_ROOTS_DEF;
    localparam int NBITS = (NRT << NLV) * 2;
    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_size_bytes = '0;
    logic [31:0] i_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_result_address;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_block_allocator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // allocator shadow state
    logic [3:0]  lvl_reg;
    logic [4:0]  root_reg;
    logic [4:0]  shift_reg;
    bit          free_bits [NBITS];
    logic [11:0] free_cnt [NLV];

    typedef struct packed {
        t_status     st;
        logic [31:0] addr;
    } t_reply;

    t_reply      pending_replies [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          quiet_tx = 1'b0;
    bit          quiet_rx = 1'b0;
    logic [31:0] granted [$];

    function automatic int levels_now();
        if (lvl_reg == 0) return 1;
        if (lvl_reg > NLV) return NLV;
        return lvl_reg;
    endfunction

    function automatic longint roots_now();
        if (root_reg == 0) return 1;
        if (root_reg > NRT) return NRT;
        return root_reg;
    endfunction

    function automatic longint base_of(int lv);
        longint b = 0;
        for (int k = 0; k < lv && k < NLV; k++) b += longint'(NRT) << (NLV - 1 - k);
        return b;
    endfunction

    function automatic longint blocks_at(int lv);
        int lc = levels_now();
        if (lv >= lc) return 0;
        return roots_now() << (lc - 1 - lv);
    endfunction

    function automatic bit is_free(int lv, longint i);
        if (i >= blocks_at(lv)) return 1'b0;
        return free_bits[base_of(lv) + i];
    endfunction

    function automatic void mark(int lv, longint i, bit v);
        longint p;
        if (i >= blocks_at(lv)) return;
        p = base_of(lv) + i;
        if (free_bits[p] == v) return;
        free_bits[p] = v;
        free_cnt[lv] = v ? free_cnt[lv] + 1 : free_cnt[lv] - 1;
    endfunction

    function automatic void rebuild_store();
        int top = levels_now() - 1;
        longint n = blocks_at(top);
        foreach (free_bits[j]) free_bits[j] = 1'b0;
        foreach (free_cnt[j]) free_cnt[j] = '0;
        for (longint i = 0; i < n; i++) mark(top, i, 1'b1);
    endfunction

    function automatic t_status size_level(logic [31:0] size, output int lv);
        int s = 0;
        lv = 0;
        if (size == 0 || (size & (size - 1)) != 0) return ST_BADSIZE;
        while ((size >> s) > 1) s++;
        if (s < shift_reg) return ST_BADSIZE;
        if (s - shift_reg >= levels_now()) return ST_TOOBIG;
        lv = s - shift_reg;
        return ST_OK;
    endfunction

    function automatic t_reply allocator_step(t_kind k, logic [31:0] size, logic [31:0] addr);
        t_reply r;
        int lv, l, lc;
        bit got;
        longint idx, n;
        lc = levels_now();
        r.st = ST_OK;
        r.addr = '0;
        if (k == K_REINIT) begin
            rebuild_store();
            return r;
        end
        r.st = size_level(size, lv);
        if (r.st != ST_OK) return r;
        if (k == K_ALLOC) begin
            got = 1'b0;
            idx = 0;
            for (l = lv; l < lc && !got; l++) begin
                n = blocks_at(l);
                for (longint i = 0; i < n; i++)
                    if (is_free(l, i)) begin
                        idx = i;
                        got = 1'b1;
                        break;
                    end
            end
            if (!got) begin
                r.st = ST_UNAVAILABLE;
                return r;
            end
            l--;
            mark(l, idx, 1'b0);
            while (l > lv) begin
                l--;
                idx = idx << 1;
                mark(l, idx + 1, 1'b1);
            end
            r.addr = 32'(idx * longint'(size));
            return r;
        end
        if (addr % size != 0) begin
            r.st = ST_MISALIGNED;
            return r;
        end
        idx = addr / size;
        if (idx >= blocks_at(lv)) begin
            r.st = ST_UNAVAILABLE;
            return r;
        end
        if (k == K_ALLOC_AT) begin
            got = 1'b0;
            for (l = lv; l < lc; l++)
                if (is_free(l, idx >> (l - lv))) begin
                    got = 1'b1;
                    break;
                end
            if (!got) begin
                r.st = ST_UNAVAILABLE;
                return r;
            end
            mark(l, idx >> (l - lv), 1'b0);
            while (l > lv) begin
                l--;
                mark(l, (idx >> (l - lv)) ^ 1, 1'b1);
            end
            r.addr = addr;
            return r;
        end
        for (l = lv; l < lc; l++)
            if (is_free(l, idx >> (l - lv))) begin
                r.st = ST_ALREADYFREE;
                return r;
            end
        l = lv;
        while (l + 1 < lc && is_free(l, idx ^ 1)) begin
            mark(l, idx ^ 1, 1'b0);
            idx = idx >> 1;
            l++;
        end
        mark(l, idx, 1'b1);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result beat checker
    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected beat", o_status, 0);
            end else begin
                w = pending_replies.pop_front();
                if (o_status !== w.st) report_mismatch("status", o_status, w.st);
                if (o_result_address !== w.addr)
                    report_mismatch("result_address", o_result_address, w.addr);
            end
        end
        i_out_stall <= !quiet_rx && ($urandom_range(99) < 12);
    end

    task automatic send_item(t_kind k, logic [31:0] size, logic [31:0] addr);
        t_reply w;
        i_in_valid <= 1'b1;
        i_kind <= k;
        i_size_bytes <= size;
        i_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        w = allocator_step(k, size, addr);
        pending_replies.push_back(w);
        if (k == K_ALLOC || k == K_ALLOC_AT) begin
            if (w.st == ST_OK) granted.push_back(w.addr);
        end
        if (!quiet_tx && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_LEVEL_COUNT: lvl_reg = val[3:0];
            REG_ROOT_COUNT: root_reg = val[4:0];
            default: shift_reg = val[4:0];
        endcase
    endtask

    task automatic set_geometry(int lc, int rc, int sh);
        drain_results();
        write_reg(REG_LEVEL_COUNT, lc);
        write_reg(REG_ROOT_COUNT, rc);
        write_reg(REG_MIN_SHIFT, sh);
        granted.delete();
        send_item(K_REINIT, 0, 0);
    endtask

    function automatic logic [31:0] rand_size();
        int s = int'(shift_reg) + $urandom_range(levels_now());
        if ($urandom_range(19) == 0) return $urandom;
        if (s > 31) s = 31;
        return 32'(1) << s;
    endfunction

    task automatic test_directed();
        logic [31:0] mn = 32'(1) << shift_reg;
        send_item(K_ALLOC, 0, 0);
        send_item(K_ALLOC, 32'hFFFF_FFFF, 0);
        send_item(K_ALLOC, mn >> 1, 0);
        send_item(K_ALLOC, mn << levels_now(), 0);
        send_item(K_ALLOC, mn, 0);
        send_item(K_ALLOC, mn, 0);
        send_item(K_FREE, mn, 0);
        send_item(K_FREE, mn, 0);
        send_item(K_FREE, mn, mn);
        send_item(K_ALLOC_AT, mn << 1, mn);
        send_item(K_ALLOC_AT, mn << 1, 32'hFFFF_FFC0);
        send_item(K_FREE, mn << 1, 32'hFFFF_FF80);
        send_item(K_ALLOC_AT, mn << 2, mn << 2);
        send_item(K_ALLOC_AT, mn << 2, mn << 2);
        send_item(K_FREE, mn << 2, mn << 2);
        send_item(K_FREE, mn << 7, 0);
        send_item(K_ALLOC, mn << 7, 0);
        send_item(K_REINIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int count);
        logic [31:0] sz, ad;
        int pick, j;
        for (int n = 0; n < count; n++) begin
            sz = rand_size();
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_item(K_ALLOC, sz, $urandom);
            end else if (pick < 55) begin
                ad = sz * $urandom_range(roots_now() << levels_now());
                send_item(K_ALLOC_AT, sz, ($urandom_range(15) == 0) ? $urandom : ad);
            end else if (pick < 90 && granted.size() != 0) begin
                j = $urandom_range(granted.size() - 1);
                ad = granted[j];
                granted.delete(j);
                send_item(K_FREE, sz, ad);
            end else if (pick < 97) begin
                send_item(K_FREE, sz, sz * $urandom_range(roots_now() << levels_now()));
            end else begin
                granted.delete();
                send_item(K_REINIT, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_full_pause();
        test_random(30);
        drain_results();
        test_random(30);
    endtask

    task automatic test_no_idle();
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        test_random(120);
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    initial begin
        lvl_reg = RST_LEVEL_COUNT;
        root_reg = RST_ROOT_COUNT;
        shift_reg = RST_MIN_SHIFT;
        rebuild_store();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150);
        test_full_pause();
        test_no_idle();
        set_geometry(1, 1, 0);
        test_directed();
        test_random(60);
        set_geometry(15, 31, 16);
        test_random(100);
        set_geometry(3, 0, 31);
        test_random(40);
        set_geometry(4, 5, 2);
        test_directed();
        test_random(120);
        set_geometry(RST_LEVEL_COUNT, RST_ROOT_COUNT, RST_MIN_SHIFT);
        test_random(60);
        drain_results();
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
